// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the gate decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/rgd_pkg.sv -----
// Types and constants of the radar gate run-length decoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rgd_pkg;

	localparam logic [1:0] MODE_HEADER  = 2'd0;
	localparam logic [1:0] MODE_LITERAL = 2'd1;
	localparam logic [1:0] MODE_DONE    = 2'd2;

	localparam logic [15:0] MISSING_BITS = 16'h8000;
	localparam logic [14:0] RUN_MASK     = 15'h7FFF;

	typedef struct packed {
		logic [15:0] code_word;
		logic        first_of_row;
		logic        last_of_row;
	} rgd_in_t;

	typedef struct packed {
		logic signed [15:0] gate_value;
		logic [15:0]        repeat_count;
		logic               row_done;
		logic [15:0]        decoded_gates;
	} rgd_out_t;

	// Up to two results produced by one code word.
	typedef struct packed {
		logic [1:0] count;
		rgd_out_t   r0;
		rgd_out_t   r1;
	} rgd_res_t;

endpackage

// ----- hdl/rgd_decode.sv -----
// Row decoder: state registers, gate count register and the decode logic.
// Depends on rgd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgd_decode #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_data,
	input  logic            take,
	input  rgd_pkg::rgd_in_t item,
	output rgd_pkg::rgd_res_t res
);
	import rgd_pkg::*;

	logic [1:0]             mode_q, mode_d;
	logic [14:0]            lit_q, lit_d;
	logic [COUNT_WIDTH-1:0] done_q, done_d;
	logic                   miss_q, miss_d;
	logic [15:0]            gpr_q;

	logic [1:0]             e_mode;
	logic [14:0]            e_lit;
	logic [COUNT_WIDTH-1:0] e_done;
	logic                   e_miss;
	logic [COUNT_WIDTH-1:0] gpr_ext, left, n_ext, done_new, fill_base;
	logic [14:0]            n, lit_dec;
	logic                   fin_lead, fin_tail, word_end;

	assign gpr_ext = COUNT_WIDTH'(gpr_q);

	always_comb begin
		// A first word of a row clears the state before it is decoded.
		if (item.first_of_row) begin
			e_mode = MODE_HEADER;
			e_lit  = '0;
			e_done = '0;
			e_miss = 1'b0;
		end else begin
			e_mode = mode_q;
			e_lit  = lit_q;
			e_done = done_q;
			e_miss = miss_q;
		end
	end

	assign left     = (gpr_ext > e_done) ? gpr_ext - e_done : '0;
	assign n        = (COUNT_WIDTH'(item.code_word[14:0] & RUN_MASK) > left) ?
		left[14:0] : item.code_word[14:0];
	assign n_ext    = COUNT_WIDTH'(n);
	assign word_end = (item.code_word == 16'd0) || (item.code_word == 16'd1);
	assign lit_dec  = (e_lit != '0) ? e_lit - 15'd1 : e_lit;

	always_comb begin
		mode_d   = e_mode;
		lit_d    = e_lit;
		done_d   = e_done;
		miss_d   = e_miss;
		fin_lead = 1'b0;
		fin_tail = 1'b0;
		done_new = e_done;
		res      = '0;
		unique case (e_mode)
			MODE_LITERAL: begin
				done_new = e_done + COUNT_WIDTH'(1);
				done_d   = done_new;
				lit_d    = lit_dec;
				if (lit_dec == '0) begin
					mode_d = MODE_HEADER;
				end
				res.r0.gate_value   = signed'(item.code_word);
				res.r0.repeat_count = 16'd1;
				res.count           = 2'd1;
				fin_tail = (done_new >= gpr_ext) || item.last_of_row;
			end
			MODE_HEADER: begin
				priority if (e_done >= gpr_ext || word_end) begin
					fin_lead = 1'b1;
				end else if (item.code_word[15]) begin
					miss_d = 1'b0;
					if (item.last_of_row || n == '0) begin
						fin_lead = 1'b1;
					end else begin
						lit_d  = n;
						mode_d = MODE_LITERAL;
					end
				end else if (e_miss) begin
					fin_lead = 1'b1;
				end else begin
					miss_d   = 1'b1;
					done_new = e_done + n_ext;
					done_d   = done_new;
					res.r0.gate_value   = signed'(MISSING_BITS);
					res.r0.repeat_count = 16'(n);
					res.count           = 2'd1;
					fin_tail = (done_new >= gpr_ext) || item.last_of_row;
				end
			end
			default: ;
		endcase

		// The closing fill result goes in the first slot or behind the run.
		fill_base = fin_lead ? e_done : done_new;
		if (fin_lead || fin_tail) begin
			mode_d = MODE_DONE;
			lit_d  = '0;
		end
		if (fin_lead) begin
			res.count                = 2'd1;
			res.r0.gate_value        = signed'(MISSING_BITS);
			res.r0.repeat_count      = (gpr_ext > fill_base) ?
				16'(gpr_ext - fill_base) : 16'd0;
			res.r0.row_done          = 1'b1;
			res.r0.decoded_gates     = fill_base[15:0];
		end
		if (fin_tail) begin
			res.count                = 2'd2;
			res.r1.gate_value        = signed'(MISSING_BITS);
			res.r1.repeat_count      = (gpr_ext > fill_base) ?
				16'(gpr_ext - fill_base) : 16'd0;
			res.r1.row_done          = 1'b1;
			res.r1.decoded_gates     = fill_base[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			lit_q  <= '0;
			done_q <= '0;
			miss_q <= 1'b0;
			gpr_q  <= 16'd1024;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				lit_q  <= lit_d;
				done_q <= done_d;
				miss_q <= miss_d;
			end
			if (cfg_we) begin
				gpr_q <= cfg_data;
			end
		end
	end

	`ASSERT_IMPLIES(a_pair_ends_row, clk, arst_n, take && res.count == 2'd2,
		res.r1.row_done && !res.r0.row_done)
	`ASSERT_IMPLIES(a_done_is_silent, clk, arst_n,
		take && mode_q == MODE_DONE && !item.first_of_row, res.count == 2'd0)

endmodule

// ----- hdl/rgd_out_fifo.sv -----
// Result queue: takes up to two results per cycle and hands out one.
// Depends on rgd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  rgd_pkg::rgd_res_t push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output rgd_pkg::rgd_out_t result
);
	import rgd_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rgd_out_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign result    = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// Room for a worst-case pair of results.
	assign room      = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.count);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`ASSERT_IMPLIES(a_push_has_room, clk, arst_n, push.count != 2'd0,
		count_q <= CNT_W'(DEPTH - 2))

endmodule

// ----- hdl/radar_gate_rle_decoder_top.sv -----
// Top level of the radar gate run-length decoder.
// Depends on rgd_pkg, rgd_decode and rgd_out_fifo.
`timescale 1ns / 1ps

// One code word is taken per cycle while the queue has room: it lands in an
// input register, is decoded there against the row state and its zero, one
// or two results are written into a four-entry result queue, from which the
// first result is offered on the output. The output side hands out one
// result per cycle while out_ready is high, so a word that yields a run
// followed by the closing fill takes two output transfers, and the input
// stalls only when the queue lacks room for two results. Write gates_per_row
// only while the block is idle.
module radar_gate_rle_decoder_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rgd_pkg::rgd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rgd_pkg::rgd_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);
	import rgd_pkg::*;

	logic     valid_s1;
	rgd_in_t  item_s1;
	logic     room, take;
	rgd_res_t res, push;

	assign cfg_ready = 1'b1;
	assign take      = valid_s1 && room;
	assign in_ready  = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	rgd_decode #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.take    (take),
		.item    (item_s1),
		.res     (res)
	);

	always_comb begin
		push = res;
		if (!take) begin
			push.count = 2'd0;
		end
	end

	rgd_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result)
	);

endmodule
